// ----- rtl/tset_pkg.sv -----
// Shared types, codes and helpers for the time-sorted entry table.
// No dependencies; used by tset_cmp and time_sorted_entry_table.
`default_nettype none

package tset_pkg;

  // Field widths of one stored entry
  localparam int ID_W   = 16;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int RWY_W  = 8;

  // Key = hour*60 + minute; largest raw key is 31*60+63 = 1923
  localparam int KEY_W        = 11;
  localparam int MIN_PER_HOUR = 60;

  // Default table depth
  localparam int CAPACITY_DEF = 16;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [HOUR_W-1:0] dep_h;
    logic [MIN_W-1:0]  dep_m;
    logic [HOUR_W-1:0] arr_h;
    logic [MIN_W-1:0]  arr_m;
    logic [RWY_W-1:0]  runway;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef logic [KEY_W-1:0] key_t;

  // Command codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_INS_LAST  = 3'd1,
    S_INS_SHIFT = 3'd2,
    S_INS_PLACE = 3'd3,
    S_SCAN      = 3'd4,
    S_REM_SHIFT = 3'd5,
    S_LIST      = 3'd6
  } state_e;

  // Compare unit flags
  typedef struct packed {
    logic id_eq;   // stored id equals command id
    logic key_ge;  // stored key >= command key
    logic key_gt;  // stored key >  command key
  } cmp_t;

  // Departure time key; hour*60 done as (h<<6) - (h<<2)
  function automatic key_t key_of(input logic [HOUR_W-1:0] hour,
                                  input logic [MIN_W-1:0] minute);
    key_t h;
    h = KEY_W'(hour);
    return (h << 6) - (h << 2) + KEY_W'(minute);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tset_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tset_cmp.sv -----
// Shared compare unit: key and id checks of the entry read from the table.
// Depends on tset_pkg.
`default_nettype none

module tset_cmp (
  input  wire tset_pkg::entry_t rd_entry,
  input  wire tset_pkg::key_t   ref_key,
  input  wire [tset_pkg::ID_W-1:0] ref_id,
  output tset_pkg::cmp_t        flags
);

  tset_pkg::key_t rd_key;

  // key of the stored entry
  assign rd_key = tset_pkg::key_of(rd_entry.dep_h, rd_entry.dep_m);

  assign flags.id_eq  = (rd_entry.id == ref_id);
  assign flags.key_ge = (rd_key >= ref_key);
  assign flags.key_gt = (rd_key >  ref_key);

endmodule

`default_nettype wire

// ----- rtl/time_sorted_entry_table.sv -----
// Time-sorted entry table: top level with sequencer, entry RAM and compare unit.
// Depends on tset_pkg, tset_ram, tset_cmp.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------------
//  command  | start / busy     | opcode, flight_id, depart_*, arrive_*, runway_number
//  result   | strobe           | status, out_id, out_*, last_result
//
// One command runs through the table one entry per cycle through the RAM read
// port and the shared compare unit. Insert walks back from the last entry
// shifting each one up; find and remove scan from the head; list gives one
// result beat per entry, one per cycle. A full insert, and any command on an
// empty table, finish from idle without raising busy. busy is high while a
// command runs; the result beat lands the cycle after the final step. Synchronous
// reset empties the table at once (count only); the receiver cannot stall.
`default_nettype none

module time_sorted_entry_table #(
  parameter int CAPACITY = tset_pkg::CAPACITY_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire  [1:0]                   opcode,
  input  wire  [tset_pkg::ID_W-1:0]    flight_id,
  input  wire  [tset_pkg::HOUR_W-1:0]  depart_hour,
  input  wire  [tset_pkg::MIN_W-1:0]   depart_minute,
  input  wire  [tset_pkg::HOUR_W-1:0]  arrive_hour,
  input  wire  [tset_pkg::MIN_W-1:0]   arrive_minute,
  input  wire  [tset_pkg::RWY_W-1:0]   runway_number,
  output logic                         strobe,
  output logic [1:0]                   status,
  output logic [tset_pkg::ID_W-1:0]    out_id,
  output logic [tset_pkg::HOUR_W-1:0]  out_depart_hour,
  output logic [tset_pkg::MIN_W-1:0]   out_depart_minute,
  output logic [tset_pkg::HOUR_W-1:0]  out_arrive_hour,
  output logic [tset_pkg::MIN_W-1:0]   out_arrive_minute,
  output logic [tset_pkg::RWY_W-1:0]   out_runway,
  output logic                         last_result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  tset_pkg::state_e state, state_next;
  logic [AW-1:0]    idx, idx_next;
  logic [CW-1:0]    cnt, cnt_next;

  // latched command
  tset_pkg::op_e    op_q;
  tset_pkg::entry_t cmd_entry;
  tset_pkg::key_t   cmd_key;

  // RAM and compare unit
  tset_pkg::entry_t in_entry, rd_data, wr_data;
  logic             we;
  logic [AW-1:0]    wr_addr;
  tset_pkg::cmp_t   flags;

  // result beat control
  logic             emit, emit_last, load;
  logic [1:0]       emit_status;
  tset_pkg::entry_t load_data, res_entry;

  logic accept, at_end, full, shift;

  assign in_entry.id     = flight_id;
  assign in_entry.dep_h  = depart_hour;
  assign in_entry.dep_m  = depart_minute;
  assign in_entry.arr_h  = arrive_hour;
  assign in_entry.arr_m  = arrive_minute;
  assign in_entry.runway = runway_number;

  assign busy   = (state != tset_pkg::S_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt == CW'(CAPACITY));
  assign at_end = (CW'(idx) == cnt - CW'(1));

  tset_ram #(
    .WIDTH (tset_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx_next),
    .rdata (rd_data)
  );

  tset_cmp u_cmp (
    .rd_entry (rd_data),
    .ref_key  (cmd_key),
    .ref_id   (cmd_entry.id),
    .flags    (flags)
  );

  // state, index and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tset_pkg::S_IDLE;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= tset_pkg::op_e'(opcode);
      cmd_entry <= in_entry;
      cmd_key   <= tset_pkg::key_of(depart_hour, depart_minute);
    end
  end

  // result registers; payload loads ahead of the beat on a remove hit
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
    if (load) begin
      res_entry <= load_data;
    end
    if (emit) begin
      status      <= emit_status;
      last_result <= emit_last;
    end
  end

  assign out_id            = res_entry.id;
  assign out_depart_hour   = res_entry.dep_h;
  assign out_depart_minute = res_entry.dep_m;
  assign out_arrive_hour   = res_entry.arr_h;
  assign out_arrive_minute = res_entry.arr_m;
  assign out_runway        = res_entry.runway;

  // in the last-entry check an equal key appends; while shifting it moves up
  assign shift = (state == tset_pkg::S_INS_LAST) ? flags.key_gt : flags.key_ge;

  // sequencer
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    cnt_next    = cnt;
    we          = 1'b0;
    wr_addr     = idx;
    wr_data     = rd_data;
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_status = tset_pkg::ST_OK;
    load        = 1'b0;
    load_data   = '0;

    unique case (state)
      tset_pkg::S_IDLE: begin
        if (start) begin
          unique case (tset_pkg::op_e'(opcode))
            tset_pkg::OP_INSERT: begin
              if (full) begin
                emit        = 1'b1;
                emit_status = tset_pkg::ST_FULL;
                load        = 1'b1;
              end else if (cnt == '0) begin
                we        = 1'b1;
                wr_addr   = '0;
                wr_data   = in_entry;
                cnt_next  = cnt + CW'(1);
                emit      = 1'b1;
                load      = 1'b1;
                load_data = in_entry;
              end else begin
                idx_next   = AW'(cnt - CW'(1));
                state_next = tset_pkg::S_INS_LAST;
              end
            end
            tset_pkg::OP_FIND, tset_pkg::OP_REMOVE: begin
              if (cnt == '0) begin
                emit        = 1'b1;
                emit_status = tset_pkg::ST_NOT_FOUND;
                load        = 1'b1;
              end else begin
                idx_next   = '0;
                state_next = tset_pkg::S_SCAN;
              end
            end
            tset_pkg::OP_LIST: begin
              if (cnt == '0) begin
                emit        = 1'b1;
                emit_status = tset_pkg::ST_EMPTY;
                load        = 1'b1;
              end else begin
                idx_next   = '0;
                state_next = tset_pkg::S_LIST;
              end
            end
          endcase
        end
      end

      // walk down from the last entry, moving larger keys up one slot (equal keys too, below the last entry)
      tset_pkg::S_INS_LAST, tset_pkg::S_INS_SHIFT: begin
        we      = 1'b1;
        wr_addr = idx + AW'(1);
        if (shift) begin
          if (idx == '0) begin
            state_next = tset_pkg::S_INS_PLACE;
          end else begin
            idx_next   = idx - AW'(1);
            state_next = tset_pkg::S_INS_SHIFT;
          end
        end else begin
          wr_data    = cmd_entry;
          cnt_next   = cnt + CW'(1);
          emit       = 1'b1;
          load       = 1'b1;
          load_data  = cmd_entry;
          state_next = tset_pkg::S_IDLE;
        end
      end

      // every entry moved up: new entry goes to the head
      tset_pkg::S_INS_PLACE: begin
        we         = 1'b1;
        wr_addr    = '0;
        wr_data    = cmd_entry;
        cnt_next   = cnt + CW'(1);
        emit       = 1'b1;
        load       = 1'b1;
        load_data  = cmd_entry;
        state_next = tset_pkg::S_IDLE;
      end

      // id search from the head
      tset_pkg::S_SCAN: begin
        if (flags.id_eq) begin
          load      = 1'b1;
          load_data = rd_data;
          if (op_q == tset_pkg::OP_FIND) begin
            emit       = 1'b1;
            state_next = tset_pkg::S_IDLE;
          end else if (at_end) begin
            cnt_next   = cnt - CW'(1);
            emit       = 1'b1;
            state_next = tset_pkg::S_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = tset_pkg::S_REM_SHIFT;
          end
        end else if (at_end) begin
          emit        = 1'b1;
          emit_status = tset_pkg::ST_NOT_FOUND;
          load        = 1'b1;
          state_next  = tset_pkg::S_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      // close the gap after a removed entry
      tset_pkg::S_REM_SHIFT: begin
        we      = 1'b1;
        wr_addr = idx - AW'(1);
        if (at_end) begin
          cnt_next   = cnt - CW'(1);
          emit       = 1'b1;
          state_next = tset_pkg::S_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      // one beat per entry
      tset_pkg::S_LIST: begin
        emit      = 1'b1;
        emit_last = at_end;
        load      = 1'b1;
        load_data = rd_data;
        if (at_end) begin
          state_next = tset_pkg::S_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      default: begin
        state_next = tset_pkg::S_IDLE;
      end
    endcase
  end

  // count never passes the table depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted command either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (strobe || busy))
    else $error("accepted command dropped");

  // a non-final beat is always followed by more work
  a_more_beats: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_result) |-> busy)
    else $error("list stopped before its last beat");

  // the count changes only with a final result beat
  a_cnt_change: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (cnt != $past(cnt))) |-> (strobe && last_result))
    else $error("count changed without a result");

endmodule

`default_nettype wire
